// ===== hdl/tdf_pkg.sv =====
// ----------------------------------------------------------------------------
// tdf_pkg: shared types and constants of the trial division factorizer
// Control and status bundles between the sequencer and the serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

  localparam int unsigned SMALLEST_PRIME = 2;
  localparam int unsigned FIRST_ODD_DIVISOR = 3;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== hdl/tdf_if.sv =====
// ----------------------------------------------------------------------------
// tdf_if: request and result channels of the trial division factorizer
// Valid/ready channels; a request or result moves when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdf_num_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface tdf_fac_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] factor;
  logic         last;
  logic         trivial;

  modport source (output valid, output factor, output last, output trivial, input ready);
  modport sink (input valid, input factor, input last, input trivial, output ready);
endinterface

`default_nettype wire

// ===== hdl/tdf_div.sv =====
// ----------------------------------------------------------------------------
// tdf_div: bit-serial restoring divider
// One quotient bit per cycle; quotient and remainder are valid when done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_div #(
  parameter int unsigned W = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tdf_pkg::div_ctrl_t  ctrl_i,
  input  wire logic [W-1:0]        dividend_i,
  input  wire logic [W-1:0]        divisor_i,
  output tdf_pkg::div_stat_t       stat_o,
  output logic [W-1:0]             quot_o,
  output logic [W-1:0]             rem_o
);

  localparam int unsigned CW = $clog2(W);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  quot_q;
  logic [W-1:0]  rem_q;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;
  logic [W-1:0]  rem_d;

  assign shifted = {rem_q, quot_q[W-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign fits    = (shifted >= {1'b0, divisor_i});
  assign rem_d   = fits ? diff[W-1:0] : shifted[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quot_q <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W - 1);
        quot_q <= dividend_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        quot_q <= {quot_q[W-2:0], fits};
        rem_q  <= rem_d;
        cnt_q  <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== hdl/trial_division_factorizer.sv =====
// ----------------------------------------------------------------------------
// trial_division_factorizer: prime factorization by trial division
// Splits each requested number into its prime factors, smallest first.
//
// req_i carries one number per request; res_o returns one result per prime
// factor in ascending order with repetition, last set on the final one.
// Inputs 0 and 1 give a single result that echoes the input with trivial
// and last set. Factors of two are stripped one at a time by shifting. Each
// odd trial divisor takes one pass of the bit-serial divider, which yields
// both the remainder test and the divisor-squared bound. One request is
// worked at a time; req_i.ready is high only between requests.
// Results leave through an output register; while the receiver stalls the
// sequencer waits with the next factor and resumes once the register frees.
// Reset returns the block to idle with no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_factorizer #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tdf_num_if.sink    req_i,
  tdf_fac_if.source  res_o
);

  localparam int unsigned W = VALUE_WIDTH;
  localparam logic [W-1:0] ONE   = W'(1);
  localparam logic [W-1:0] TWO   = W'(tdf_pkg::SMALLEST_PRIME);
  localparam logic [W-1:0] THREE = W'(tdf_pkg::FIRST_ODD_DIVISOR);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TWOS,
    ST_NEXT,
    ST_WAIT,
    ST_EMIT
  } state_e;

  state_e             st_q;
  state_e             after_q;
  logic [W-1:0]       rem_q;
  logic [W-1:0]       div_q;
  logic [W-1:0]       fac_q;
  logic               last_q;
  logic               triv_q;
  logic               div_start_q;
  logic               out_valid_q;
  logic [W-1:0]       out_fac_q;
  logic               out_last_q;
  logic               out_triv_q;

  tdf_pkg::div_ctrl_t div_ctrl;
  tdf_pkg::div_stat_t div_stat;
  logic [W-1:0]       quot;
  logic [W-1:0]       remd;
  logic [W-1:0]       num;

  assign num      = req_i.number;
  assign div_ctrl = '{start: div_start_q};

  tdf_div #(
    .W (W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (rem_q),
    .divisor_i  (div_q),
    .stat_o     (div_stat),
    .quot_o     (quot),
    .rem_o      (remd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      after_q     <= ST_IDLE;
      rem_q       <= '0;
      div_q       <= '0;
      fac_q       <= '0;
      last_q      <= 1'b0;
      triv_q      <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_fac_q   <= '0;
      out_last_q  <= 1'b0;
      out_triv_q  <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && res_o.ready && (st_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            if (num <= ONE) begin
              fac_q   <= num;
              last_q  <= 1'b1;
              triv_q  <= 1'b1;
              after_q <= ST_IDLE;
              st_q    <= ST_EMIT;
            end else begin
              rem_q <= num;
              st_q  <= ST_TWOS;
            end
          end
        end
        ST_TWOS: begin
          if (!rem_q[0]) begin
            fac_q   <= TWO;
            last_q  <= (rem_q == TWO);
            triv_q  <= 1'b0;
            rem_q   <= rem_q >> 1;
            after_q <= (rem_q == TWO) ? ST_IDLE : ST_TWOS;
            st_q    <= ST_EMIT;
          end else begin
            div_q       <= THREE;
            div_start_q <= 1'b1;
            st_q        <= ST_WAIT;
          end
        end
        ST_NEXT: begin
          div_start_q <= 1'b1;
          st_q        <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_stat.done) begin
            if (quot < div_q) begin
              // divisor squared exceeds what is left, so the rest is prime
              fac_q   <= rem_q;
              last_q  <= 1'b1;
              triv_q  <= 1'b0;
              after_q <= ST_IDLE;
              st_q    <= ST_EMIT;
            end else if (remd == '0) begin
              fac_q   <= div_q;
              last_q  <= 1'b0;
              triv_q  <= 1'b0;
              rem_q   <= quot;
              after_q <= ST_NEXT;
              st_q    <= ST_EMIT;
            end else begin
              div_q <= div_q + TWO;
              st_q  <= ST_NEXT;
            end
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || res_o.ready) begin
            out_valid_q <= 1'b1;
            out_fac_q   <= fac_q;
            out_last_q  <= last_q;
            out_triv_q  <= triv_q;
            st_q        <= after_q;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready   = (st_q == ST_IDLE);
  assign res_o.valid   = out_valid_q;
  assign res_o.factor  = out_fac_q;
  assign res_o.last    = out_last_q;
  assign res_o.trivial = out_triv_q;

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !div_stat.busy)
    else $error("divider busy while idle");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (st_q == ST_WAIT))
    else $error("divider result outside wait state");

  a_odd_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WAIT) |-> div_q[0])
    else $error("even trial divisor");

  a_trivial_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_triv_q) |-> out_last_q)
    else $error("trivial result not marked last");

endmodule

`default_nettype wire

// ===== dv/tdf_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_result_checker: factor stream checker for the trial division factorizer
// Watches both channels. Each accepted request is split into its prime
// factors, and those factors are queued in order. Each accepted result is
// compared field by field with the oldest queued factor.
// ----------------------------------------------------------------------------
module tdf_result_checker #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  logic                   req_ready_i,
  input  logic [VALUE_WIDTH-1:0] req_number_i,
  input  logic                   res_valid_i,
  input  logic                   res_ready_i,
  input  logic [VALUE_WIDTH-1:0] res_factor_i,
  input  logic                   res_last_i,
  input  logic                   res_trivial_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o,
  output int unsigned            factors_seen_o
);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] factor;
    logic                   last;
    logic                   trivial;
  } prime_factor_t;

  prime_factor_t pending_factors[$];
  int unsigned   fail_count = 0;
  int unsigned   pending_count = 0;
  int unsigned   factors_seen = 0;

  assign fail_count_o   = fail_count;
  assign pending_o      = pending_count;
  assign factors_seen_o = factors_seen;

  task automatic report_mismatch(input string what, input logic [VALUE_WIDTH-1:0] want,
                                 input logic [VALUE_WIDTH-1:0] got);
    $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    fail_count++;
  endtask

  function automatic void queue_factor(input prime_factor_t item);
    pending_factors.insert(pending_factors.size(), item);
  endfunction

  function automatic void split_into_primes(input logic [VALUE_WIDTH-1:0] number);
    logic [VALUE_WIDTH-1:0] rest;
    logic [VALUE_WIDTH-1:0] divisor;
    logic [VALUE_WIDTH-1:0] found[$];
    if (number <= 1) begin
      queue_factor('{number, 1'b1, 1'b1});
      return;
    end
    rest = number;
    while (!rest[0]) begin
      found.insert(found.size(), VALUE_WIDTH'(tdf_pkg::SMALLEST_PRIME));
      rest = rest >> 1;
    end
    divisor = VALUE_WIDTH'(tdf_pkg::FIRST_ODD_DIVISOR);
    // divisor <= rest / divisor keeps the square bound free of overflow
    while (rest > 1 && divisor <= rest / divisor) begin
      if (rest % divisor == 0) begin
        found.insert(found.size(), divisor);
        rest = rest / divisor;
      end else begin
        divisor = divisor + 2;
      end
    end
    if (rest > 1) found.insert(found.size(), rest);
    foreach (found[i]) queue_factor('{found[i], i == found.size() - 1, 1'b0});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    prime_factor_t want;
    if (!rst_ni) begin
      pending_factors.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        factors_seen++;
        if (pending_factors.size() == 0) begin
          report_mismatch("result with no request pending", '0, res_factor_i);
        end else begin
          want = pending_factors.pop_front();
          if (res_factor_i !== want.factor) report_mismatch("factor", want.factor, res_factor_i);
          if (res_last_i !== want.last) report_mismatch("last", want.last, res_last_i);
          if (res_trivial_i !== want.trivial) begin
            report_mismatch("trivial", want.trivial, res_trivial_i);
          end
        end
      end
      if (req_valid_i && req_ready_i) split_into_primes(req_number_i);
    end
    pending_count = pending_factors.size();
  end

endmodule

// ===== dv/trial_division_factorizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_factorizer_tb: testbench of the trial division factorizer
// Sends edge values first, then random numbers built mostly from small
// factors so that trial division stays short. Both sides stall at random,
// with one stretch free of stalls. A separate checker predicts the factors.
// ----------------------------------------------------------------------------
module trial_division_factorizer_tb;

  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned CYCLE_LIMIT  = 6_000_000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RANDOM_COUNT = 81;
  localparam int unsigned STALL_PCT    = 7;
  localparam int unsigned N_DIRECTED   = 19;
  localparam logic [VALUE_WIDTH-1:0] DIRECTED_NUMBERS [N_DIRECTED] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd27, 32'd49, 32'd97, 32'd121,
    32'd1024, 32'h8000_0000, 32'hC000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
    32'd111546435, 32'd196611, 32'd4294967291
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        stall_en = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned factors_seen;

  always #5 clk_i = ~clk_i;

  tdf_num_if #(.W(VALUE_WIDTH)) req_if ();
  tdf_fac_if #(.W(VALUE_WIDTH)) res_if ();

  trial_division_factorizer #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  tdf_result_checker #(.VALUE_WIDTH(VALUE_WIDTH)) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_if.valid),
    .req_ready_i   (req_if.ready),
    .req_number_i  (req_if.number),
    .res_valid_i   (res_if.valid),
    .res_ready_i   (res_if.ready),
    .res_factor_i  (res_if.factor),
    .res_last_i    (res_if.last),
    .res_trivial_i (res_if.trivial),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .factors_seen_o(factors_seen)
  );

  always @(negedge clk_i) begin
    res_if.ready <= !(stall_en && $urandom_range(0, 99) < STALL_PCT);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d factors pending", cycle_count, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_number(input logic [VALUE_WIDTH-1:0] number);
    @(negedge clk_i);
    while (stall_en && $urandom_range(0, 99) < STALL_PCT) begin
      req_if.valid  <= 1'b0;
      req_if.number <= $urandom;
      @(negedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.number <= number;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    requests_sent++;
  endtask

  // factors stay small so each request needs few trial divisors
  function automatic logic [VALUE_WIDTH-1:0] pick_number();
    int unsigned     kind;
    int unsigned     n_factors;
    int unsigned     i;
    longint unsigned product;
    longint unsigned factor;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      product   = 1;
      n_factors = $urandom_range(1, 12);
      for (i = 0; i < n_factors; i++) begin
        factor = (i == 0 && $urandom_range(0, 1)) ? $urandom_range(2, 65535)
                                                  : $urandom_range(2, 255);
        if (product * factor <= 64'hFFFF_FFFF) product = product * factor;
      end
      return product[VALUE_WIDTH-1:0];
    end else if (kind < 75) begin
      return $urandom & ((32'd1 << $urandom_range(1, 20)) - 32'd1);
    end else if (kind < 85) begin
      return ($urandom_range(1, 255) | 32'd1) << $urandom_range(0, 23);
    end else if (kind < 90) begin
      return $urandom_range(0, 1);
    end
    return $urandom_range(2, 1023) * $urandom_range(2, 1023);
  endfunction

  initial begin
    int unsigned i;
    req_if.valid  = 1'b0;
    req_if.number = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < N_DIRECTED; i++) push_number(DIRECTED_NUMBERS[i]);
    for (i = 0; i < RANDOM_COUNT; i++) begin
      // no stalls on either side in the middle stretch
      stall_en = !(i >= 40 && i < 70);
      push_number(pick_number());
    end
    stall_en = 1'b1;

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d requests: zero, one, powers of two, a 32-bit prime, random products",
             requests_sent);
    $display("%0d factors compared, with and without random stalls on both channels",
             factors_seen);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
